>>> design/assert_macros.svh
// Assertion macros used by quad_x_motor_mixer.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clk edge outside of reset.
`define QX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
// Check that a condition never holds outside of reset.
`define QX_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);
`else
`define QX_ASSERT(label, prop, msg)
`define QX_NEVER(label, cond, msg)
`endif
`endif

>>> design/qxmm_pkg.sv
// Types and constants for the quad-X motor mixer.
// Used by quad_x_motor_mixer; depends on nothing.
package qxmm_pkg;

  localparam int MOTOR_CNT  = 4;
  localparam int NUM_AXES   = 4;
  localparam int CMD_W      = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = CMD_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int ADJ_W      = SUM_W + 3;
  localparam int FRAC_W     = 16;
  localparam int OUT_W      = 10;
  localparam int ROW_W      = COEF_W * NUM_AXES;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [ROW_W-1:0] MIX_ROW_1_RST = 64'hF000_F000_1000_1000;
  localparam logic [ROW_W-1:0] MIX_ROW_2_RST = 64'h1000_F000_F000_1000;
  localparam logic [ROW_W-1:0] MIX_ROW_3_RST = 64'hF000_1000_F000_1000;
  localparam logic [ROW_W-1:0] MIX_ROW_4_RST = 64'h1000_1000_1000_1000;
  localparam logic [OUT_W-1:0] OUT_MIN_RST   = 10'd0;
  localparam logic [OUT_W-1:0] OUT_MAX_RST   = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_ROW_1    = 3'd0,
    CFG_MIX_ROW_2    = 3'd1,
    CFG_MIX_ROW_3    = 3'd2,
    CFG_MIX_ROW_4    = 3'd3,
    CFG_OUT_MIN      = 3'd4,
    CFG_OUT_MAX      = 3'd5,
    CFG_DESAT_ENABLE = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] throttle_cmd;
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
    logic                    armed;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] motor_front_left;
    logic [OUT_W-1:0] motor_front_right;
    logic [OUT_W-1:0] motor_rear_right;
    logic [OUT_W-1:0] motor_rear_left;
    logic             saturated;
  } out_t;

endpackage

>>> design/quad_x_motor_mixer.sv
// Quad-X motor mixer top level: 4x4 mix, desaturation shift, clamp.
// Depends on qxmm_pkg and assert_macros.svh.
//
// Usage: each request on the in_ channel carries throttle, roll, pitch and
// yaw demands (signed Q12.4) and an armed flag. The out_ channel returns one
// result per request: four motor commands in integer counts and a saturated
// flag. A disarmed request returns all zeros.
// The cfg_ port writes one register per cycle while cfg_wr_en is high; the
// index follows the register list (mix rows 1..4, out_min, out_max,
// desat_enable). Write it only while no request is in flight.
// Pipeline: products, row sums, max/min, shift amount, shift and clamp into
// the output register; out_valid is the valid flag of that register.
// Throughput is one request per cycle while the receiver does not stall, set by
// the five-stage pipeline with one multiplier per coefficient in the product stage.
// When the receiver stalls, the result holds in the output register and the
// earlier stages keep filling empty slots; in_stall rises only once every
// stage holds a request. Reset (rst_n low, synchronous) empties the pipeline
// and loads the standard X matrix, out_min 0, out_max 1023, desat on.
`include "assert_macros.svh"

module quad_x_motor_mixer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  qxmm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output qxmm_pkg::out_t                   out_data,
  input  logic                             cfg_wr_en,
  input  logic [qxmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qxmm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NM = qxmm_pkg::MOTOR_CNT;
  localparam int NA = qxmm_pkg::NUM_AXES;
  localparam int CW = qxmm_pkg::COEF_W;
  localparam int PW = qxmm_pkg::PROD_W;
  localparam int SW = qxmm_pkg::SUM_W;
  localparam int AW = qxmm_pkg::ADJ_W;
  localparam int FW = qxmm_pkg::FRAC_W;
  localparam int OW = qxmm_pkg::OUT_W;

  // Configuration registers
  logic [qxmm_pkg::ROW_W-1:0] mix_row_r [NM];
  logic [OW-1:0]              out_min_r;
  logic [OW-1:0]              out_max_r;
  logic                       desat_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_row_r[0] <= qxmm_pkg::MIX_ROW_1_RST;
      mix_row_r[1] <= qxmm_pkg::MIX_ROW_2_RST;
      mix_row_r[2] <= qxmm_pkg::MIX_ROW_3_RST;
      mix_row_r[3] <= qxmm_pkg::MIX_ROW_4_RST;
      out_min_r    <= qxmm_pkg::OUT_MIN_RST;
      out_max_r    <= qxmm_pkg::OUT_MAX_RST;
      desat_en_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      case (qxmm_pkg::cfg_idx_t'(cfg_index))
        qxmm_pkg::CFG_MIX_ROW_1:    mix_row_r[0] <= cfg_wdata[qxmm_pkg::ROW_W-1:0];
        qxmm_pkg::CFG_MIX_ROW_2:    mix_row_r[1] <= cfg_wdata[qxmm_pkg::ROW_W-1:0];
        qxmm_pkg::CFG_MIX_ROW_3:    mix_row_r[2] <= cfg_wdata[qxmm_pkg::ROW_W-1:0];
        qxmm_pkg::CFG_MIX_ROW_4:    mix_row_r[3] <= cfg_wdata[qxmm_pkg::ROW_W-1:0];
        qxmm_pkg::CFG_OUT_MIN:      out_min_r    <= cfg_wdata[OW-1:0];
        qxmm_pkg::CFG_OUT_MAX:      out_max_r    <= cfg_wdata[OW-1:0];
        qxmm_pkg::CFG_DESAT_ENABLE: desat_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Bounds scaled into the fixed-point domain
  logic signed [AW-1:0] lo_fx;
  logic signed [AW-1:0] hi_fx;
  assign lo_fx = $signed({{(AW-OW-FW){1'b0}}, out_min_r, {FW{1'b0}}});
  assign hi_fx = $signed({{(AW-OW-FW){1'b0}}, out_max_r, {FW{1'b0}}});

  // Pipeline registers and per-stage ready
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r      <= in_valid;
      if (rdy2) s2_v_r      <= s1_v_r;
      if (rdy3) s3_v_r      <= s2_v_r;
      if (rdy4) s4_v_r      <= s3_v_r;
      if (rdy5) out_valid_r <= s4_v_r;
    end
  end

  // Stage 1: one product per coefficient
  logic signed [qxmm_pkg::CMD_W-1:0] cmd [NA];
  logic signed [PW-1:0] prod_r [NM][NA];
  logic                 s1_armed_r;

  assign cmd[0] = in_data.throttle_cmd;
  assign cmd[1] = in_data.roll_cmd;
  assign cmd[2] = in_data.pitch_cmd;
  assign cmd[3] = in_data.yaw_cmd;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_armed_r <= in_data.armed;
      for (int i = 0; i < NM; i++) begin
        for (int k = 0; k < NA; k++) begin
          prod_r[i][k] <= $signed(mix_row_r[i][k*CW +: CW]) * cmd[k];
        end
      end
    end
  end

  // Stage 2: row sums
  logic signed [SW-1:0] sum_nxt [NM];
  logic signed [SW-1:0] sum_r   [NM];
  logic                 s2_armed_r;

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      sum_nxt[i] = '0;
      for (int k = 0; k < NA; k++) begin
        sum_nxt[i] = sum_nxt[i] + {{(SW-PW){prod_r[i][k][PW-1]}}, prod_r[i][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_armed_r <= s1_armed_r;
      sum_r      <= sum_nxt;
    end
  end

  // Stage 3: largest and smallest motor sums
  logic signed [SW-1:0] mx_a, mx_b, mn_a, mn_b;
  logic signed [SW-1:0] s3_sum_r [NM];
  logic signed [SW-1:0] s3_mx_r;
  logic signed [SW-1:0] s3_mn_r;
  logic                 s3_armed_r;

  assign mx_a = (sum_r[1] > sum_r[0]) ? sum_r[1] : sum_r[0];
  assign mx_b = (sum_r[3] > sum_r[2]) ? sum_r[3] : sum_r[2];
  assign mn_a = (sum_r[1] < sum_r[0]) ? sum_r[1] : sum_r[0];
  assign mn_b = (sum_r[3] < sum_r[2]) ? sum_r[3] : sum_r[2];

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_armed_r <= s2_armed_r;
      s3_sum_r   <= sum_r;
      s3_mx_r    <= (mx_b > mx_a) ? mx_b : mx_a;
      s3_mn_r    <= (mn_b < mn_a) ? mn_b : mn_a;
    end
  end

  // Stage 4: total uniform shift; excess and deficit add when both apply
  logic signed [AW-1:0] mx_ext, mn_ext;
  logic signed [AW-1:0] excess_adj, deficit_adj;
  logic                 over_hi, under_lo;
  logic signed [AW-1:0] s4_shift_r;
  logic signed [SW-1:0] s4_sum_r [NM];
  logic                 s4_sat_r;
  logic                 s4_armed_r;

  assign mx_ext      = {{(AW-SW){s3_mx_r[SW-1]}}, s3_mx_r};
  assign mn_ext      = {{(AW-SW){s3_mn_r[SW-1]}}, s3_mn_r};
  assign over_hi     = desat_en_r && (mx_ext > hi_fx);
  assign under_lo    = desat_en_r && (mn_ext < lo_fx);
  assign excess_adj  = over_hi  ? (hi_fx - mx_ext) : '0;
  assign deficit_adj = under_lo ? (lo_fx - mn_ext) : '0;

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_armed_r <= s3_armed_r;
      s4_sum_r   <= s3_sum_r;
      s4_shift_r <= excess_adj + deficit_adj;
      s4_sat_r   <= over_hi || under_lo;
    end
  end

  // Stage 5: apply the shift, clamp low bound first, drop the fraction
  logic signed [AW-1:0] adj   [NM];
  logic [OW-1:0]        motor [NM];
  logic                 clamp_hit;
  qxmm_pkg::out_t       out_nxt;
  qxmm_pkg::out_t       out_data_r;

  always_comb begin
    clamp_hit = 1'b0;
    for (int i = 0; i < NM; i++) begin
      adj[i] = {{(AW-SW){s4_sum_r[i][SW-1]}}, s4_sum_r[i]} + s4_shift_r;
      if (adj[i] < lo_fx) begin
        motor[i]  = out_min_r;
        clamp_hit = 1'b1;
      end else if (adj[i] > hi_fx) begin
        motor[i]  = out_max_r;
        clamp_hit = 1'b1;
      end else begin
        motor[i] = adj[i][FW +: OW];
      end
    end
    out_nxt.motor_front_left  = motor[0];
    out_nxt.motor_front_right = motor[1];
    out_nxt.motor_rear_right  = motor[2];
    out_nxt.motor_rear_left   = motor[3];
    out_nxt.saturated         = s4_sat_r || clamp_hit;
    // disarmed request: force the whole result to zero
    if (!s4_armed_r) out_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  `QX_ASSERT(a_accept_fills_s1, (in_valid && !in_stall) |=> s1_v_r, "accepted request lost")
  `QX_ASSERT(a_shift_flags_sat, (s4_v_r && (s4_shift_r != '0)) |-> s4_sat_r, "shift without sat")
  `QX_NEVER(a_full_not_stalled, in_stall && !(s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r), "stall with empty slot")

endmodule

>>> test/quad_x_motor_mixer_tb.sv
// Self-checking testbench for the quad-X motor mixer: drives mixed demand
// requests through several register settings and checks every result.
// Depends on qxmm_pkg and the quad_x_motor_mixer RTL.
`timescale 1ns / 1ps

module quad_x_motor_mixer_tb;

  localparam logic [qxmm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int Q4           = 16;  // Q12.4 scale of one count

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  qxmm_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  qxmm_pkg::out_t                  out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [qxmm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [qxmm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the mixer registers
  logic [qxmm_pkg::ROW_W-1:0] mix_coef [qxmm_pkg::MOTOR_CNT];
  logic [qxmm_pkg::OUT_W-1:0] lim_lo;
  logic [qxmm_pkg::OUT_W-1:0] lim_hi;
  logic                       desat_on;

  qxmm_pkg::in_t  pending [$];
  qxmm_pkg::out_t motor_expect [$];
  qxmm_pkg::out_t want;
  int   fail_count = 0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   stall_tick = 0;
  int   quiet_cycles = 0;

  quad_x_motor_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Expected motor commands for one request under the shadow registers.
  function automatic qxmm_pkg::out_t mix_predict(qxmm_pkg::in_t req);
    longint                     cmd [qxmm_pkg::NUM_AXES];
    longint                     sum [qxmm_pkg::MOTOR_CNT];
    longint                     lo;
    longint                     hi;
    longint                     top;
    longint                     bot;
    logic [qxmm_pkg::OUT_W-1:0] mot [qxmm_pkg::MOTOR_CNT];
    logic                       sat;
    qxmm_pkg::out_t             res;
    res = '0;
    if (!req.armed) return res;
    cmd[0] = longint'($signed(req.throttle_cmd));
    cmd[1] = longint'($signed(req.roll_cmd));
    cmd[2] = longint'($signed(req.pitch_cmd));
    cmd[3] = longint'($signed(req.yaw_cmd));
    lo = longint'(lim_lo) << qxmm_pkg::FRAC_W;
    hi = longint'(lim_hi) << qxmm_pkg::FRAC_W;
    sat = 1'b0;
    for (int i = 0; i < qxmm_pkg::MOTOR_CNT; i++) begin
      sum[i] = 0;
      for (int k = 0; k < qxmm_pkg::NUM_AXES; k++)
        sum[i] += longint'($signed(mix_coef[i][qxmm_pkg::COEF_W*k +: qxmm_pkg::COEF_W]))
                  * cmd[k];
    end
    top = sum[0];
    bot = sum[0];
    for (int i = 1; i < qxmm_pkg::MOTOR_CNT; i++) begin
      if (sum[i] > top) top = sum[i];
      if (sum[i] < bot) bot = sum[i];
    end
    if (desat_on) begin
      // deficit is measured from the unshifted minimum, so both shifts add
      if (top > hi) begin
        for (int i = 0; i < qxmm_pkg::MOTOR_CNT; i++) sum[i] -= top - hi;
        sat = 1'b1;
      end
      if (bot < lo) begin
        for (int i = 0; i < qxmm_pkg::MOTOR_CNT; i++) sum[i] += lo - bot;
        sat = 1'b1;
      end
    end
    for (int i = 0; i < qxmm_pkg::MOTOR_CNT; i++) begin
      if (sum[i] < lo) begin
        mot[i] = lim_lo;
        sat = 1'b1;
      end else if (sum[i] > hi) begin
        mot[i] = lim_hi;
        sat = 1'b1;
      end else begin
        mot[i] = qxmm_pkg::OUT_W'(sum[i] >>> qxmm_pkg::FRAC_W);
      end
    end
    res.motor_front_left  = mot[0];
    res.motor_front_right = mot[1];
    res.motor_rear_right  = mot[2];
    res.motor_rear_left   = mot[3];
    res.saturated         = sat;
    return res;
  endfunction

  function automatic qxmm_pkg::in_t mk_req(int thr, int rol, int pit, int yaw, bit arm);
    qxmm_pkg::in_t r;
    r.throttle_cmd = qxmm_pkg::CMD_W'(thr);
    r.roll_cmd     = qxmm_pkg::CMD_W'(rol);
    r.pitch_cmd    = qxmm_pkg::CMD_W'(pit);
    r.yaw_cmd      = qxmm_pkg::CMD_W'(yaw);
    r.armed        = arm;
    return r;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 3))
      0: return 32767;
      1: return -32768;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly flyable demands, then raw noise, disarmed requests and extremes.
  function automatic qxmm_pkg::in_t rand_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return mk_req($urandom_range(0, 1100 * Q4), int'($urandom_range(0, 12800)) - 6400,
                    int'($urandom_range(0, 12800)) - 6400,
                    int'($urandom_range(0, 12800)) - 6400, 1'b1);
    if (sel < 85)
      return mk_req($urandom, $urandom, $urandom, $urandom, 1'b1);
    if (sel < 93)
      return mk_req($urandom, $urandom, $urandom, $urandom, 1'b0);
    return mk_req(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(), 1'b1);
  endfunction

  function automatic logic [qxmm_pkg::ROW_W-1:0] rand_row();
    logic [qxmm_pkg::ROW_W-1:0] row;
    for (int k = 0; k < qxmm_pkg::NUM_AXES; k++) begin
      if ($urandom_range(0, 3) == 0)
        row[qxmm_pkg::COEF_W*k +: qxmm_pkg::COEF_W] = qxmm_pkg::COEF_W'($urandom);
      else
        row[qxmm_pkg::COEF_W*k +: qxmm_pkg::COEF_W] =
          qxmm_pkg::COEF_W'(int'($urandom_range(0, 8192)) - 4096);
    end
    return row;
  endfunction

  task automatic cfg_write(logic [qxmm_pkg::CFG_IDX_W-1:0] idx,
                           logic [qxmm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      qxmm_pkg::CFG_MIX_ROW_1, qxmm_pkg::CFG_MIX_ROW_2, qxmm_pkg::CFG_MIX_ROW_3,
      qxmm_pkg::CFG_MIX_ROW_4:    mix_coef[idx[1:0]] = val;
      qxmm_pkg::CFG_OUT_MIN:      lim_lo = val[qxmm_pkg::OUT_W-1:0];
      qxmm_pkg::CFG_OUT_MAX:      lim_hi = val[qxmm_pkg::OUT_W-1:0];
      qxmm_pkg::CFG_DESAT_ENABLE: desat_on = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_limits(int lo, int hi, bit desat);
    cfg_write(qxmm_pkg::CFG_OUT_MIN, qxmm_pkg::CFG_DATA_W'(lo));
    cfg_write(qxmm_pkg::CFG_OUT_MAX, qxmm_pkg::CFG_DATA_W'(hi));
    cfg_write(qxmm_pkg::CFG_DESAT_ENABLE, qxmm_pkg::CFG_DATA_W'(desat));
  endtask

  task automatic load_rows(logic [qxmm_pkg::ROW_W-1:0] r1, logic [qxmm_pkg::ROW_W-1:0] r2,
                           logic [qxmm_pkg::ROW_W-1:0] r3, logic [qxmm_pkg::ROW_W-1:0] r4);
    cfg_write(qxmm_pkg::CFG_MIX_ROW_1, r1);
    cfg_write(qxmm_pkg::CFG_MIX_ROW_2, r2);
    cfg_write(qxmm_pkg::CFG_MIX_ROW_3, r3);
    cfg_write(qxmm_pkg::CFG_MIX_ROW_4, r4);
  endtask

  // Wait until every queued request has been sent and has come back, then let
  // the pipeline settle.
  task automatic drain();
    while (pending.size() != 0 || in_valid || motor_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending.push_back(rand_req());
  endtask

  // Request driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) motor_expect.push_back(mix_predict(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= pending.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: switch between no stall, light, heavy and periodic.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (motor_expect.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        fail_count++;
      end else begin
        want = motor_expect.pop_front();
        if (out_data.motor_front_left !== want.motor_front_left) begin
          $error("motor_front_left: expected %0d, got %0d",
                 want.motor_front_left, out_data.motor_front_left);
          fail_count++;
        end
        if (out_data.motor_front_right !== want.motor_front_right) begin
          $error("motor_front_right: expected %0d, got %0d",
                 want.motor_front_right, out_data.motor_front_right);
          fail_count++;
        end
        if (out_data.motor_rear_right !== want.motor_rear_right) begin
          $error("motor_rear_right: expected %0d, got %0d",
                 want.motor_rear_right, out_data.motor_rear_right);
          fail_count++;
        end
        if (out_data.motor_rear_left !== want.motor_rear_left) begin
          $error("motor_rear_left: expected %0d, got %0d",
                 want.motor_rear_left, out_data.motor_rear_left);
          fail_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0d, got %0d", want.saturated, out_data.saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request, result or register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mix_coef[0] = qxmm_pkg::MIX_ROW_1_RST;
    mix_coef[1] = qxmm_pkg::MIX_ROW_2_RST;
    mix_coef[2] = qxmm_pkg::MIX_ROW_3_RST;
    mix_coef[3] = qxmm_pkg::MIX_ROW_4_RST;
    lim_lo = qxmm_pkg::OUT_MIN_RST;
    lim_hi = qxmm_pkg::OUT_MAX_RST;
    desat_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset matrix: hover, truncation, each shift alone and together, extremes
    pending.push_back(mk_req(0, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(500 * Q4, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(500 * Q4 + 7, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(1023 * Q4, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(1023 * Q4 + 15, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(32767, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(-32768, 0, 0, 0, 1'b1));
    pending.push_back(mk_req(900 * Q4, 0, 0, 200 * Q4, 1'b1));
    pending.push_back(mk_req(100 * Q4, 0, 300 * Q4, 0, 1'b1));
    pending.push_back(mk_req(500 * Q4, 800 * Q4, 0, 0, 1'b1));
    pending.push_back(mk_req(500 * Q4, -3 * Q4, 5 * Q4, -7 * Q4, 1'b1));
    pending.push_back(mk_req(32767, 32767, 32767, 32767, 1'b1));
    pending.push_back(mk_req(-32768, -32768, -32768, -32768, 1'b1));
    pending.push_back(mk_req(32767, -32768, 32767, -32768, 1'b1));
    pending.push_back(mk_req(-1, -1, -1, -1, 1'b1));
    pending.push_back(mk_req('h5555, 'h5555, 'h5555, 'h5555, 1'b1));
    pending.push_back(mk_req('hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 1'b1));
    pending.push_back(mk_req(32767, 32767, 32767, 32767, 1'b0));
    pending.push_back(mk_req(-32768, -32768, -32768, -32768, 1'b0));
    pending.push_back(mk_req(500 * Q4, 800 * Q4, 0, 0, 1'b0));
    queue_random(200);
    drain();

    load_rows(rand_row(), rand_row(), rand_row(), rand_row());
    load_limits($urandom_range(0, 300), $urandom_range(600, 1023), 1'b1);
    cfg_close();
    queue_random(220);
    drain();

    // Desaturation off: sums go straight to the clamp
    load_limits($urandom_range(0, 200), $urandom_range(700, 1023), 1'b0);
    cfg_close();
    queue_random(200);
    drain();

    // Inverted limits
    load_limits($urandom_range(512, 1023), $urandom_range(0, 511), $urandom_range(0, 1));
    cfg_close();
    queue_random(150);
    drain();

    // Extreme coefficients and full-range limits
    load_rows(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
              64'h0000_0000_0000_0000, 64'h7FFF_8000_7FFF_8000);
    load_limits(0, 1023, 1'b1);
    cfg_close();
    queue_random(200);
    drain();

    load_limits(1023, 0, 1'b1);
    cfg_close();
    queue_random(150);
    drain();

    // Equal limits; the spare index must leave every register alone
    load_rows(rand_row(), rand_row(), rand_row(), rand_row());
    cfg_write(qxmm_pkg::CFG_OUT_MIN, qxmm_pkg::CFG_DATA_W'(lim_lo));
    lim_hi = qxmm_pkg::OUT_W'($urandom_range(0, 1023));
    load_limits(lim_hi, lim_hi, 1'b1);
    cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
    cfg_close();
    queue_random(200);
    drain();

    load_rows(qxmm_pkg::MIX_ROW_1_RST, qxmm_pkg::MIX_ROW_2_RST,
              qxmm_pkg::MIX_ROW_3_RST, qxmm_pkg::MIX_ROW_4_RST);
    load_limits(qxmm_pkg::OUT_MIN_RST, qxmm_pkg::OUT_MAX_RST, 1'b1);
    cfg_close();
    queue_random(200);
    drain();

    load_rows(rand_row(), rand_row(), rand_row(), rand_row());
    load_limits($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1));
    cfg_close();
    queue_random(200);
    drain();

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/qxmm_pkg.sv
design/quad_x_motor_mixer.sv
test/quad_x_motor_mixer_tb.sv
